>>> hw/rtl/sed_pkg.sv
package sed_pkg;

    // fixed build settings
    localparam int unsigned SAMPLE_RATE_HZ = 16000;
    localparam int unsigned PERIOD_FRAMES  = 512;
    localparam int unsigned MAX_RECOVERIES = 3;
    localparam int unsigned MAX_TIMEOUT_MS = 300000;

    // field and counter widths
    localparam int unsigned MS_W   = 19;
    localparam int unsigned THR_W  = 16;
    localparam int unsigned CNT_W  = 24;
    localparam int unsigned REC_W  = 4;
    localparam int unsigned PER_W  = $clog2(PERIOD_FRAMES + 2);
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [REC_W-1:0] REC_MAX = {REC_W{1'b1}};
    localparam logic [THR_W-1:0] THR_LIMIT = 16'd32767;

    // ms to frames: whole frames per ms plus a rounded-up remainder part
    localparam int unsigned FRAMES_PER_MS = SAMPLE_RATE_HZ / 1000;
    localparam int unsigned RATE_REM      = SAMPLE_RATE_HZ % 1000;
    localparam int unsigned WHOLE_W       = MS_W + $clog2(FRAMES_PER_MS + 1);
    localparam int unsigned REM_W         = MS_W + 10;
    localparam int unsigned RECIP_SH      = 39;
    localparam int unsigned RECIP_W       = 30;
    localparam int unsigned PROD_W        = REM_W + RECIP_W;
    localparam int unsigned BACK_W        = REM_W + 10;
    localparam longint unsigned RECIP     = (64'd1 << RECIP_SH) / 64'd1000 + 64'd1;

    // item kinds
    typedef enum logic [1:0] {
        KIND_START     = 2'd0,
        KIND_SAMPLE    = 2'd1,
        KIND_READ_FAIL = 2'd2,
        KIND_CANCEL    = 2'd3
    } t_kind;

    // recognizer status codes
    localparam logic [2:0] ST_SPEECH    = 3'd1;
    localparam logic [2:0] ST_ENDPOINT  = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;

    // result codes
    typedef enum logic [3:0] {
        OUT_CONTINUE   = 4'd0,
        OUT_NATIVE     = 4'd1,
        OUT_FALLBACK   = 4'd2,
        OUT_TIMEOUT    = 4'd3,
        OUT_CANCELLED  = 4'd4,
        OUT_MALFORMED  = 4'd5,
        OUT_BAD_STATUS = 4'd6,
        OUT_REC_FAILED = 4'd7,
        OUT_BAD_CONFIG = 4'd8
    } t_outcome;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEECH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIL_SIL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_UTT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [MS_W-1:0]   timeout_ms;
        logic signed [15:0] sample;
        logic              last_in_period;
        logic [2:0]        feed_status;
        logic              recovery_ok;
        logic              failure_is_zero;
    } t_item;

    typedef struct packed {
        logic              bad;
        logic [CNT_W-1:0]  min_frames;
        logic [CNT_W-1:0]  sil_frames;
        logic [CNT_W-1:0]  utt_frames;
        logic [THR_W-1:0]  threshold;
    } t_cfg_info;

    typedef struct packed {
        logic              valid;
        t_outcome          outcome;
        logic              done;
        logic [CNT_W-1:0]  captured;
        logic [CNT_W-1:0]  speech;
    } t_result;

    // saturating counter add
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // ceil(rate * ms / 1000), saturated; the divide by 1000 is a reciprocal multiply
    function automatic logic [CNT_W-1:0] ms_to_frames(input logic [MS_W-1:0] ms);
        logic [WHOLE_W-1:0] whole;
        logic [REM_W-1:0]   y;
        logic [PROD_W-1:0]  prod;
        logic [REM_W-1:0]   q;
        logic [BACK_W-1:0]  back;
        logic               rnd;
        logic [WHOLE_W:0]   sum;
        whole = WHOLE_W'(ms) * WHOLE_W'(FRAMES_PER_MS);
        y     = REM_W'(ms) * REM_W'(RATE_REM);
        prod  = PROD_W'(y) * PROD_W'(RECIP);
        q     = REM_W'(prod >> RECIP_SH);
        back  = BACK_W'(q) * BACK_W'(1000);
        rnd   = (back != BACK_W'(y));
        sum   = (WHOLE_W + 1)'(whole) + (WHOLE_W + 1)'(q) + (WHOLE_W + 1)'(rnd);
        return (sum > (WHOLE_W + 1)'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum);
    endfunction

endpackage

>>> hw/rtl/speech_endpoint_detector.sv
// Speech endpoint detector.
// Input channel (i_in_valid / o_in_ready) takes one word per cycle: a session
// start, one PCM sample, a capture read failure or a cancel. Results leave on
// the output channel (o_out_valid / i_out_ready); a word gives at most one
// result, and in-budget mid-period samples and non-start words outside a
// session give none. Registers are written over the config channel
// (i_cfg_valid / o_cfg_ready, always ready); the user must write them only
// while no session work is in flight, as the block does not enforce it. A word
// passes the input register, then the result register. Throughput: one word
// per cycle unless the output stalls; the session update is a single pass of
// compare, add and multiply logic between the two registers. Stalls: when the
// receiver holds i_out_ready low the result register keeps its word and the
// input register can still take one more word; after that o_in_ready drops
// until the result is taken. Reset (synchronous, active low) ends any session,
// clears all counters and loads the default endpoint settings; the first word
// is taken the cycle after reset is released.
module speech_endpoint_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_kind,
    input  logic [sed_pkg::MS_W-1:0]      i_timeout_ms,
    input  logic signed [15:0]            i_sample,
    input  logic                          i_last_in_period,
    input  logic [2:0]                    i_feed_status,
    input  logic                          i_recovery_ok,
    input  logic                          i_failure_is_zero,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [3:0]                    o_outcome,
    output logic                          o_session_done,
    output logic [sed_pkg::CNT_W-1:0]     o_captured_frames,
    output logic [sed_pkg::CNT_W-1:0]     o_speech_frames,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sed_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sed_pkg::MS_W-1:0]      i_cfg_data
);
    import sed_pkg::*;

    logic      r_in_valid;
    t_item     r_item;
    logic      r_out_valid;
    t_result   r_res;
    logic      adv;
    logic      in_take;
    t_cfg_info cfg;
    t_result   res;

    assign o_cfg_ready = 1'b1;

    // handshake control
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_take    = i_in_valid && o_in_ready;

    sed_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sed_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.kind            <= i_kind;
            r_item.timeout_ms      <= i_timeout_ms;
            r_item.sample          <= i_sample;
            r_item.last_in_period  <= i_last_in_period;
            r_item.feed_status     <= i_feed_status;
            r_item.recovery_ok     <= i_recovery_ok;
            r_item.failure_is_zero <= i_failure_is_zero;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_outcome         = r_res.outcome;
    assign o_session_done    = r_res.done;
    assign o_captured_frames = r_res.captured;
    assign o_speech_frames   = r_res.speech;

    // speech is only counted on frames that were captured
    a_speech_le_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_speech_frames <= o_captured_frames))
        else $error("speech count above captured count");

    // a fallback endpoint needs counted speech
    a_fallback_has_speech: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_outcome == OUT_FALLBACK)) |-> (o_speech_frames != '0))
        else $error("fallback endpoint with no speech frames");

    // continue never closes a session, every other outcome does
    a_done_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_session_done == (o_outcome != OUT_CONTINUE)))
        else $error("session done flag disagrees with outcome");

    // a buffered word is kept while the result register is stalled
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> (r_in_valid && $stable(r_item)))
        else $error("buffered word lost during output stall");

endmodule

>>> hw/rtl/sed_cfg.sv
module sed_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [sed_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sed_pkg::MS_W-1:0]         i_cfg_data,
    output sed_pkg::t_cfg_info               o_cfg
);
    import sed_pkg::*;

    logic [MS_W-1:0]  r_min_speech_ms;
    logic [MS_W-1:0]  r_trail_sil_ms;
    logic [MS_W-1:0]  r_max_utt_ms;
    logic [THR_W-1:0] r_threshold;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speech_ms <= MS_W'(300);
            r_trail_sil_ms  <= MS_W'(800);
            r_max_utt_ms    <= MS_W'(15000);
            r_threshold     <= THR_W'(500);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_SPEECH: r_min_speech_ms <= i_cfg_data;
                CFG_TRAIL_SIL:  r_trail_sil_ms  <= i_cfg_data;
                CFG_MAX_UTT:    r_max_utt_ms    <= i_cfg_data;
                CFG_THRESHOLD:  r_threshold     <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // settings check
    always_comb begin
        o_cfg.bad = (r_min_speech_ms == '0) || (r_trail_sil_ms == '0) ||
                    (r_max_utt_ms == '0) ||
                    (r_min_speech_ms > r_max_utt_ms) ||
                    (r_trail_sil_ms > r_max_utt_ms) ||
                    (r_max_utt_ms > MS_W'(MAX_TIMEOUT_MS)) ||
                    (r_threshold == '0) || (r_threshold > THR_LIMIT);
        o_cfg.min_frames = ms_to_frames(r_min_speech_ms);
        o_cfg.sil_frames = ms_to_frames(r_trail_sil_ms);
        o_cfg.utt_frames = ms_to_frames(r_max_utt_ms);
        o_cfg.threshold  = r_threshold;
    end

endmodule

>>> hw/rtl/sed_core.sv
module sed_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  sed_pkg::t_item       i_item,
    input  sed_pkg::t_cfg_info   i_cfg,
    output sed_pkg::t_result     o_res
);
    import sed_pkg::*;

    logic             r_active,      n_active;
    logic [CNT_W-1:0] r_captured,    n_captured;
    logic [CNT_W-1:0] r_frame_limit, n_frame_limit;
    logic             r_speech_seen, n_speech_seen;
    logic [CNT_W-1:0] r_speech_cnt,  n_speech_cnt;
    logic [CNT_W-1:0] r_quiet_cnt,   n_quiet_cnt;
    logic [CNT_W-1:0] r_min_frames,  n_min_frames;
    logic [CNT_W-1:0] r_sil_frames,  n_sil_frames;
    logic [CNT_W-1:0] r_utt_frames,  n_utt_frames;
    logic [PER_W-1:0] r_period_cnt,  n_period_cnt;
    logic             r_period_quiet, n_period_quiet;
    logic [REC_W-1:0] r_rec_cnt,     n_rec_cnt;

    logic [16:0]      mag;
    logic [CNT_W-1:0] left;
    logic [PER_W-1:0] allowed;
    logic [PER_W-1:0] cnt_inc;
    logic             quiet_nx;
    logic [CNT_W-1:0] cap_sum;
    logic             seen_nx;
    logic [CNT_W-1:0] speech_sum;
    logic [CNT_W-1:0] quiet_sum;
    logic             fallback;
    logic [MS_W-1:0]  timeout_sat;
    logic [CNT_W-1:0] limit_new;
    logic             used_up;

    // per-sample datapath
    always_comb begin
        mag = i_item.sample[15] ? (17'd0 - {i_item.sample[15], i_item.sample})
                                : {1'b0, i_item.sample};
        left = (r_frame_limit > r_captured) ? (r_frame_limit - r_captured) : '0;
        allowed = (left < CNT_W'(PERIOD_FRAMES)) ? left[PER_W-1:0] : PER_W'(PERIOD_FRAMES);
        cnt_inc = r_period_cnt + PER_W'(1);
        quiet_nx = r_period_quiet && (mag <= {1'b0, i_cfg.threshold});
        cap_sum = sat_add(r_captured, CNT_W'(cnt_inc));
        seen_nx = r_speech_seen || (i_item.feed_status == ST_SPEECH);
        speech_sum = sat_add(r_speech_cnt, CNT_W'(cnt_inc));
        quiet_sum = quiet_nx ? sat_add(r_quiet_cnt, CNT_W'(cnt_inc)) : '0;
        fallback = seen_nx && ((speech_sum >= r_utt_frames) ||
                   ((speech_sum >= r_min_frames) && (quiet_sum >= r_sil_frames)));
        timeout_sat = (i_item.timeout_ms > MS_W'(MAX_TIMEOUT_MS)) ?
                      MS_W'(MAX_TIMEOUT_MS) : i_item.timeout_ms;
        limit_new = ms_to_frames(timeout_sat);
        used_up = (r_rec_cnt >= REC_W'(MAX_RECOVERIES));
    end

    // session decisions and next state
    always_comb begin
        n_active       = r_active;
        n_captured     = r_captured;
        n_frame_limit  = r_frame_limit;
        n_speech_seen  = r_speech_seen;
        n_speech_cnt   = r_speech_cnt;
        n_quiet_cnt    = r_quiet_cnt;
        n_min_frames   = r_min_frames;
        n_sil_frames   = r_sil_frames;
        n_utt_frames   = r_utt_frames;
        n_period_cnt   = r_period_cnt;
        n_period_quiet = r_period_quiet;
        n_rec_cnt      = r_rec_cnt;
        o_res.valid    = 1'b0;
        o_res.outcome  = OUT_CONTINUE;
        o_res.done     = 1'b0;

        case (i_item.kind)
            KIND_START: begin
                n_captured     = '0;
                n_frame_limit  = '0;
                n_speech_seen  = 1'b0;
                n_speech_cnt   = '0;
                n_quiet_cnt    = '0;
                n_min_frames   = '0;
                n_sil_frames   = '0;
                n_utt_frames   = '0;
                n_rec_cnt      = '0;
                n_period_cnt   = '0;
                n_period_quiet = 1'b1;
                o_res.valid    = 1'b1;
                if (i_cfg.bad) begin
                    o_res.outcome = OUT_BAD_CONFIG;
                    o_res.done    = 1'b1;
                end else begin
                    n_frame_limit = limit_new;
                    n_min_frames  = i_cfg.min_frames;
                    n_sil_frames  = i_cfg.sil_frames;
                    n_utt_frames  = i_cfg.utt_frames;
                    if (limit_new == '0) begin
                        o_res.outcome = OUT_TIMEOUT;
                        o_res.done    = 1'b1;
                    end
                end
            end
            KIND_SAMPLE: begin
                if (r_active) begin
                    n_period_cnt   = cnt_inc;
                    n_period_quiet = quiet_nx;
                    if (cnt_inc > allowed) begin
                        // period overran its budget: not counted
                        n_period_cnt   = '0;
                        n_period_quiet = 1'b1;
                        o_res.valid    = 1'b1;
                        o_res.outcome  = OUT_MALFORMED;
                        o_res.done     = 1'b1;
                    end else if (i_item.last_in_period) begin
                        n_captured     = cap_sum;
                        n_period_cnt   = '0;
                        n_period_quiet = 1'b1;
                        o_res.valid    = 1'b1;
                        if (i_item.feed_status == ST_ENDPOINT) begin
                            o_res.outcome = OUT_NATIVE;
                            o_res.done    = 1'b1;
                        end else if (i_item.feed_status == ST_CANCELLED) begin
                            o_res.outcome = OUT_CANCELLED;
                            o_res.done    = 1'b1;
                        end else begin
                            n_speech_seen = seen_nx;
                            if (seen_nx) begin
                                n_speech_cnt = speech_sum;
                                n_quiet_cnt  = quiet_sum;
                            end
                            if (fallback) begin
                                o_res.outcome = OUT_FALLBACK;
                                o_res.done    = 1'b1;
                            end else if (i_item.feed_status > ST_SPEECH) begin
                                o_res.outcome = OUT_BAD_STATUS;
                                o_res.done    = 1'b1;
                            end else if (cap_sum >= r_frame_limit) begin
                                o_res.outcome = OUT_TIMEOUT;
                                o_res.done    = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_READ_FAIL: begin
                if (r_active) begin
                    n_period_cnt   = '0;
                    n_period_quiet = 1'b1;
                    if (r_rec_cnt != REC_MAX) begin
                        n_rec_cnt = r_rec_cnt + REC_W'(1);
                    end
                    o_res.valid = 1'b1;
                    if (i_item.failure_is_zero || used_up || !i_item.recovery_ok) begin
                        o_res.outcome = OUT_REC_FAILED;
                        o_res.done    = 1'b1;
                    end
                end
            end
            KIND_CANCEL: begin
                if (r_active) begin
                    n_period_cnt   = '0;
                    n_period_quiet = 1'b1;
                    o_res.valid    = 1'b1;
                    o_res.outcome  = OUT_CANCELLED;
                    o_res.done     = 1'b1;
                end
            end
            default: ;
        endcase

        // session state after this word
        if (i_item.kind == KIND_START) begin
            n_active = !o_res.done;
        end else if (o_res.done) begin
            n_active = 1'b0;
        end
        o_res.captured = n_captured;
        o_res.speech   = n_speech_cnt;
    end

    // session state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_captured     <= '0;
            r_frame_limit  <= '0;
            r_speech_seen  <= 1'b0;
            r_speech_cnt   <= '0;
            r_quiet_cnt    <= '0;
            r_min_frames   <= '0;
            r_sil_frames   <= '0;
            r_utt_frames   <= '0;
            r_period_cnt   <= '0;
            r_period_quiet <= 1'b1;
            r_rec_cnt      <= '0;
        end else if (i_fire) begin
            r_active       <= n_active;
            r_captured     <= n_captured;
            r_frame_limit  <= n_frame_limit;
            r_speech_seen  <= n_speech_seen;
            r_speech_cnt   <= n_speech_cnt;
            r_quiet_cnt    <= n_quiet_cnt;
            r_min_frames   <= n_min_frames;
            r_sil_frames   <= n_sil_frames;
            r_utt_frames   <= n_utt_frames;
            r_period_cnt   <= n_period_cnt;
            r_period_quiet <= n_period_quiet;
            r_rec_cnt      <= n_rec_cnt;
        end
    end

endmodule
